FILE: rtl/chi_square_independence_test_core_defines.svh
// assertion macros for the chi-square core checker
`ifndef CHI_SQUARE_INDEPENDENCE_TEST_CORE_DEFINES_SVH
`define CHI_SQUARE_INDEPENDENCE_TEST_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CSI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/csi_pkg.sv
// shared types and constants of the chi-square core
package csi_pkg;

	localparam int STAT_W  = 40;
	localparam int DF_W    = 8;
	localparam int DIST_W  = 5;
	localparam int TOTAL_W = 16;
	localparam int CODE_W  = 4;
	localparam int IDX_W   = 8;

	localparam logic OP_COUNT = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CNT_RD,
		S_CNT_WR,
		S_EV_RD,
		S_EV_CHK,
		S_MUL_GO,
		S_MUL_WAIT,
		S_DIV_GO,
		S_DIV_WAIT,
		S_EV_NEXT,
		S_DF,
		S_CRIT,
		S_EMIT
	} csi_state_t;

	typedef enum logic [1:0] {
		MS_ON,
		MS_RC,
		MS_SQ,
		MS_DEN
	} csi_mstep_t;

	typedef struct packed {
		logic       accept;
		logic       load;
		logic       cnt_rd;
		logic       cnt_wr;
		logic       cell_rd;
		logic       cell_next;
		logic       mul_go;
		logic       mul_store;
		logic       div_go;
		logic       acc;
		logic       df_calc;
		logic       crit_rd;
		logic       emit;
		csi_mstep_t mstep;
	} csi_cmd_t;

	typedef struct packed {
		logic cell_last;
		logic term_needed;
		logic mul_done;
		logic div_done;
		logic item_last;
	} csi_sts_t;

endpackage

FILE: rtl/chi_square_independence_test_core.sv
// top level of the chi-square independence test core
//
//   channel  | handshake           | fields
//   ---------+---------------------+-----------------------------------------------
//   item in  | start, busy         | operation, first_category, second_category,
//            |                     | is_last, table_index, critical_value
//   result   | done (one cycle)    | statistic, degrees_of_freedom, below_critical,
//            |                     | distinct_first, distinct_second, sample_total,
//            |                     | count_saturated
//
// a load item is taken in idle; a count item runs a count-table read, then write back
// a last item then walks all CATEGORIES^2 cells; one with a zero row or column sum
// is skipped, any other gets four serial multiplies and a 40-step divide
// each cell read is cleared; S_DF, S_CRIT, S_EMIT follow; done rises as busy drops
// after reset a clearing pass over all CATEGORIES^2 cells runs with busy high
// results cannot be stalled: done is high for exactly one cycle per result
module chi_square_independence_test_core import csi_pkg::*; #(
	parameter int CATEGORIES    = 16,
	parameter int COUNT_BITS    = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [CODE_W-1:0]  first_category,
	input  logic [CODE_W-1:0]  second_category,
	input  logic               is_last,
	input  logic [IDX_W-1:0]   table_index,
	input  logic [STAT_W-1:0]  critical_value,
	output logic               done,
	output logic [STAT_W-1:0]  statistic,
	output logic [DF_W-1:0]    degrees_of_freedom,
	output logic               below_critical,
	output logic [DIST_W-1:0]  distinct_first,
	output logic [DIST_W-1:0]  distinct_second,
	output logic [TOTAL_W-1:0] sample_total,
	output logic               count_saturated
);
	csi_cmd_t cmd;
	csi_sts_t sts;

	csi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	csi_dp #(
		.CATEGORIES    (CATEGORIES),
		.COUNT_BITS    (COUNT_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.first_category     (first_category),
		.second_category    (second_category),
		.is_last            (is_last),
		.table_index        (table_index),
		.critical_value     (critical_value),
		.done               (done),
		.statistic          (statistic),
		.degrees_of_freedom (degrees_of_freedom),
		.below_critical     (below_critical),
		.distinct_first     (distinct_first),
		.distinct_second    (distinct_second),
		.sample_total       (sample_total),
		.count_saturated    (count_saturated)
	);
endmodule

FILE: rtl/csi_mul.sv
// shift-add multiplier, one multiplier bit per cycle
module csi_mul #(
	parameter int AW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [AW-1:0]   a,
	input  logic [AW-1:0]   b,
	output logic            done,
	output logic [2*AW-1:0] p
);
	localparam int CW = $clog2(AW + 1);

	logic [2*AW-1:0] a_q;
	logic [2*AW-1:0] acc_q;
	logic [AW-1:0]   b_q;
	logic [CW-1:0]   cnt_q;
	logic            run_q;
	logic            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(1));
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(AW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= (2*AW)'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign p    = acc_q;
endmodule

FILE: rtl/csi_div.sv
// restoring divider, one quotient bit per cycle, quotient capped at all ones
module csi_div #(
	parameter int NW = 80,
	parameter int DW = 48,
	parameter int QW = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] q,
	output logic          over
);
	localparam int RW = NW + 1;
	localparam int CW = $clog2(QW + 1);

	logic [RW-1:0] rem_q;
	logic [RW-1:0] den_q;
	logic [QW-1:0] lo_q;
	logic [QW-1:0] q_q;
	logic          over_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [RW-1:0] top_w;
	logic [RW-1:0] rem2_w;

	assign top_w  = RW'(num >> QW);
	assign rem2_w = {rem_q[RW-2:0], lo_q[QW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(1));
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(QW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					run_q <= 1'b0;
			end
		end
	end

	// quotient of 2^QW or more is known from the upper numerator bits alone
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= top_w;
			lo_q   <= num[QW-1:0];
			den_q  <= RW'(den);
			q_q    <= '0;
			over_q <= top_w >= RW'(den);
		end else if (run_q) begin
			lo_q <= lo_q << 1;
			if (over_q) begin
				q_q <= '1;
			end else if (rem2_w >= den_q) begin
				rem_q <= rem2_w - den_q;
				q_q   <= {q_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= rem2_w;
				q_q   <= {q_q[QW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign q    = q_q;
	assign over = over_q;
endmodule

FILE: rtl/csi_ctrl.sv
// controller state machine of the chi-square core
module csi_ctrl import csi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     operation,
	input  csi_sts_t sts,
	output csi_cmd_t cmd,
	output logic     busy
);
	csi_state_t state_q, state_d;
	csi_mstep_t mstep_q, mstep_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			mstep_q <= MS_ON;
		end else begin
			state_q <= state_d;
			mstep_q <= mstep_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mstep_d   = mstep_q;
		cmd       = '0;
		cmd.mstep = mstep_q;
		busy      = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.cell_rd   = 1'b1;
				cmd.cell_next = 1'b1;
				if (sts.cell_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (operation == OP_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.accept = 1'b1;
						state_d    = S_CNT_RD;
					end
				end
			end
			S_CNT_RD: begin
				cmd.cnt_rd = 1'b1;
				state_d    = S_CNT_WR;
			end
			S_CNT_WR: begin
				cmd.cnt_wr = 1'b1;
				state_d    = sts.item_last ? S_EV_RD : S_IDLE;
			end
			S_EV_RD: begin
				cmd.cell_rd = 1'b1;
				state_d     = S_EV_CHK;
			end
			S_EV_CHK: begin
				if (sts.term_needed) begin
					mstep_d = MS_ON;
					state_d = S_MUL_GO;
				end else begin
					state_d = S_EV_NEXT;
				end
			end
			S_MUL_GO: begin
				cmd.mul_go = 1'b1;
				state_d    = S_MUL_WAIT;
			end
			S_MUL_WAIT: begin
				if (sts.mul_done) begin
					cmd.mul_store = 1'b1;
					if (mstep_q == MS_DEN) begin
						state_d = S_DIV_GO;
					end else begin
						mstep_d = csi_mstep_t'(mstep_q + 2'd1);
						state_d = S_MUL_GO;
					end
				end
			end
			S_DIV_GO: begin
				cmd.div_go = 1'b1;
				state_d    = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.acc = 1'b1;
					state_d = S_EV_NEXT;
				end
			end
			S_EV_NEXT: begin
				cmd.cell_next = 1'b1;
				state_d       = sts.cell_last ? S_DF : S_EV_RD;
			end
			S_DF: begin
				cmd.df_calc = 1'b1;
				state_d     = S_CRIT;
			end
			S_CRIT: begin
				cmd.crit_rd = 1'b1;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

FILE: rtl/csi_dp.sv
// datapath: count table, row and column sums, term arithmetic, critical table
module csi_dp import csi_pkg::*; #(
	parameter int CATEGORIES    = 16,
	parameter int COUNT_BITS    = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  csi_cmd_t           cmd,
	output csi_sts_t           sts,
	input  logic [CODE_W-1:0]  first_category,
	input  logic [CODE_W-1:0]  second_category,
	input  logic               is_last,
	input  logic [IDX_W-1:0]   table_index,
	input  logic [STAT_W-1:0]  critical_value,
	output logic               done,
	output logic [STAT_W-1:0]  statistic,
	output logic [DF_W-1:0]    degrees_of_freedom,
	output logic               below_critical,
	output logic [DIST_W-1:0]  distinct_first,
	output logic [DIST_W-1:0]  distinct_second,
	output logic [TOTAL_W-1:0] sample_total,
	output logic               count_saturated
);
	localparam int CAT_W     = $clog2(CATEGORIES);
	localparam int CELLS     = CATEGORIES * CATEGORIES;
	localparam int CELL_W    = $clog2(CELLS);
	localparam int TAB_DEPTH = (CATEGORIES - 1) * (CATEGORIES - 1) + 1;
	localparam int TAB_W     = $clog2(TAB_DEPTH);
	localparam int DCW       = $clog2(CATEGORIES + 1);
	localparam int AW        = 2 * COUNT_BITS;
	localparam int PW        = 4 * COUNT_BITS;
	localparam int DW        = 3 * COUNT_BITS;
	localparam int NW        = PW + FRACTION_BITS;
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	// captured item
	logic [CAT_W-1:0] fc_q, sc_q;
	logic             in_ok_q, last_q;

	// cell walk
	logic [CAT_W-1:0] r_q, c_q;
	logic [CELL_W-1:0] cell_in, cell_rc, mem_a;

	logic [COUNT_BITS-1:0] cnt_mem [CELLS];
	logic [COUNT_BITS-1:0] o_q;
	logic [COUNT_BITS-1:0] mem_wd;
	logic                  mem_we;

	logic [COUNT_BITS-1:0] fsum_q [CATEGORIES];
	logic [COUNT_BITS-1:0] ssum_q [CATEGORIES];
	logic [CAT_W-1:0]      row_a, col_a;
	logic [COUNT_BITS-1:0] rs, cs;
	logic [COUNT_BITS-1:0] n_q;
	logic [DCW-1:0]        d1_q, d2_q;
	logic                  sat_q;

	logic [AW-1:0]  on_q, rc_q, d_w, mul_a, mul_b;
	logic [PW-1:0]  sq_q, mul_p;
	logic [DW-1:0]  den_q;
	logic           mul_done;
	logic [STAT_W-1:0] div_q;
	logic           div_done, div_over;

	logic [STAT_W-1:0] stat_q, crit_q;
	logic [STAT_W:0]   sum_w;
	logic              ovr_q;
	logic [TAB_W-1:0]  df_q;
	logic [2*DCW-1:0]  df_w;
	logic [STAT_W-1:0] crit_mem [TAB_DEPTH];
	logic              done_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			fc_q    <= CAT_W'(first_category);
			sc_q    <= CAT_W'(second_category);
			in_ok_q <= (int'(first_category) < CATEGORIES) &&
				(int'(second_category) < CATEGORIES);
			last_q  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
		end else if (cmd.cell_next) begin
			if (c_q == CAT_W'(CATEGORIES - 1)) begin
				c_q <= '0;
				r_q <= (r_q == CAT_W'(CATEGORIES - 1)) ? '0 : r_q + CAT_W'(1);
			end else begin
				c_q <= c_q + CAT_W'(1);
			end
		end
	end

	assign cell_in = CELL_W'(int'(fc_q) * CATEGORIES + int'(sc_q));
	assign cell_rc = CELL_W'(int'(r_q) * CATEGORIES + int'(c_q));
	assign mem_a   = cmd.cell_rd ? cell_rc : cell_in;
	assign mem_we  = (cmd.cnt_wr && in_ok_q) || cmd.cell_rd;
	assign mem_wd  = cmd.cell_rd ? '0 : ((o_q == CMAX) ? o_q : o_q + 1'b1);

	// a visited cell reads its count and is cleared in the same cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			cnt_mem[mem_a] <= mem_wd;
		if (cmd.cnt_rd || cmd.cell_rd)
			o_q <= cnt_mem[mem_a];
	end

	assign row_a = cmd.cnt_wr ? fc_q : r_q;
	assign col_a = cmd.cnt_wr ? sc_q : c_q;
	assign rs    = fsum_q[row_a];
	assign cs    = ssum_q[col_a];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CATEGORIES; i++) begin
				fsum_q[i] <= '0;
				ssum_q[i] <= '0;
			end
			n_q   <= '0;
			d1_q  <= '0;
			d2_q  <= '0;
			sat_q <= 1'b0;
		end else if (cmd.emit) begin
			for (int i = 0; i < CATEGORIES; i++) begin
				fsum_q[i] <= '0;
				ssum_q[i] <= '0;
			end
			n_q   <= '0;
			d1_q  <= '0;
			d2_q  <= '0;
			sat_q <= 1'b0;
		end else if (cmd.cnt_wr && in_ok_q) begin
			if (rs != CMAX)
				fsum_q[row_a] <= rs + 1'b1;
			if (cs != CMAX)
				ssum_q[col_a] <= cs + 1'b1;
			if (n_q != CMAX)
				n_q <= n_q + 1'b1;
			if (rs == '0)
				d1_q <= d1_q + DCW'(1);
			if (cs == '0)
				d2_q <= d2_q + DCW'(1);
			sat_q <= sat_q | (rs == CMAX) | (cs == CMAX) | (o_q == CMAX) | (n_q == CMAX);
		end
	end

	assign d_w = (on_q >= rc_q) ? on_q - rc_q : rc_q - on_q;

	always_comb begin
		case (cmd.mstep)
			MS_ON: begin
				mul_a = AW'(o_q);
				mul_b = AW'(n_q);
			end
			MS_RC: begin
				mul_a = AW'(rs);
				mul_b = AW'(cs);
			end
			MS_SQ: begin
				mul_a = d_w;
				mul_b = d_w;
			end
			MS_DEN: begin
				mul_a = rc_q;
				mul_b = AW'(n_q);
			end
			default: begin
				mul_a = AW'(o_q);
				mul_b = AW'(n_q);
			end
		endcase
	end

	csi_mul #(.AW(AW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_ff @(posedge clk) begin
		if (cmd.mul_store) begin
			case (cmd.mstep)
				MS_ON:   on_q  <= mul_p[AW-1:0];
				MS_RC:   rc_q  <= mul_p[AW-1:0];
				MS_SQ:   sq_q  <= mul_p;
				MS_DEN:  den_q <= mul_p[DW-1:0];
				default: on_q  <= mul_p[AW-1:0];
			endcase
		end
	end

	csi_div #(.NW(NW), .DW(DW), .QW(STAT_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    ({sq_q, {FRACTION_BITS{1'b0}}}),
		.den    (den_q),
		.done   (div_done),
		.q      (div_q),
		.over   (div_over)
	);

	assign sum_w = {1'b0, stat_q} + {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
			ovr_q  <= 1'b0;
		end else if (cmd.emit) begin
			stat_q <= '0;
			ovr_q  <= 1'b0;
		end else if (cmd.acc) begin
			stat_q <= sum_w[STAT_W] ? '1 : sum_w[STAT_W-1:0];
			ovr_q  <= ovr_q | div_over | sum_w[STAT_W];
		end
	end

	assign df_w = (2*DCW)'(d1_q - DCW'(1)) * (2*DCW)'(d2_q - DCW'(1));

	always_ff @(posedge clk) begin
		if (cmd.df_calc)
			df_q <= (d1_q != '0 && d2_q != '0) ? TAB_W'(df_w) : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load && (int'(table_index) < TAB_DEPTH))
			crit_mem[TAB_W'(table_index)] <= critical_value;
		if (cmd.crit_rd)
			crit_q <= crit_mem[df_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			statistic          <= stat_q;
			degrees_of_freedom <= DF_W'(df_q);
			below_critical     <= stat_q < crit_q;
			distinct_first     <= DIST_W'(d1_q);
			distinct_second    <= DIST_W'(d2_q);
			sample_total       <= TOTAL_W'(n_q);
			count_saturated    <= sat_q | ovr_q;
		end
	end

	assign done            = done_q;
	assign sts.cell_last   = (r_q == CAT_W'(CATEGORIES - 1)) && (c_q == CAT_W'(CATEGORIES - 1));
	assign sts.term_needed = (n_q != '0) && (rs != '0) && (cs != '0);
	assign sts.mul_done    = mul_done;
	assign sts.div_done    = div_done;
	assign sts.item_last   = last_q;
endmodule

FILE: rtl/csi_checker.sv
// port-level checker of the chi-square core, bound to the top level
`include "chi_square_independence_test_core_defines.svh"

module csi_checker import csi_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               operation,
	input logic [CODE_W-1:0]  first_category,
	input logic [CODE_W-1:0]  second_category,
	input logic               is_last,
	input logic [IDX_W-1:0]   table_index,
	input logic [STAT_W-1:0]  critical_value,
	input logic               done,
	input logic [STAT_W-1:0]  statistic,
	input logic [DF_W-1:0]    degrees_of_freedom,
	input logic               below_critical,
	input logic [DIST_W-1:0]  distinct_first,
	input logic [DIST_W-1:0]  distinct_second,
	input logic [TOTAL_W-1:0] sample_total,
	input logic               count_saturated
);
	`CSI_ASSERT_NXT(a_done_single, done, !done, "result strobe held longer than one cycle")
	`CSI_ASSERT_NXT(a_count_busy, start && !busy && operation == OP_COUNT, busy,
		"count item accepted without going busy")
	`CSI_ASSERT_IMP(a_df_zero, done && (distinct_first == '0 || distinct_second == '0),
		degrees_of_freedom == '0, "degrees nonzero with an empty feature")
	`CSI_ASSERT_IMP(a_done_idle, done, !busy, "result shown while busy")
endmodule

bind chi_square_independence_test_core csi_checker u_csi_checker (.*);

FILE: sim/tb_top.sv
// self-checking testbench for the chi-square independence test core
`timescale 1ns / 1ps

module tb_top;
	import csi_pkg::*;

	localparam int CATS        = 16;
	localparam int DF_DEPTH    = (CATS - 1) * (CATS - 1) + 1;
	localparam int FRAC        = 16;
	localparam logic [STAT_W-1:0] STAT_TOP = '1;
	localparam logic [15:0] COUNT_TOP = '1;
	localparam int IDLE_LIMIT  = 200000;

	typedef struct {
		logic              op;
		logic [CODE_W-1:0] fc;
		logic [CODE_W-1:0] sc;
		logic              last;
		logic [IDX_W-1:0]  idx;
		logic [STAT_W-1:0] crit;
		bit                drain;
	} sample_item_t;

	typedef struct {
		logic [STAT_W-1:0]  stat;
		logic [DF_W-1:0]    df;
		logic               below;
		logic [DIST_W-1:0]  dfirst;
		logic [DIST_W-1:0]  dsecond;
		logic [TOTAL_W-1:0] total;
		logic               sat;
	} chi_result_t;

	logic clk, arst_n, start, busy, operation, is_last, done;
	logic [CODE_W-1:0] first_category, second_category;
	logic [IDX_W-1:0] table_index;
	logic [STAT_W-1:0] critical_value, statistic;
	logic [DF_W-1:0] degrees_of_freedom;
	logic below_critical, count_saturated;
	logic [DIST_W-1:0] distinct_first, distinct_second;
	logic [TOTAL_W-1:0] sample_total;

	chi_square_independence_test_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .first_category(first_category),
		.second_category(second_category), .is_last(is_last),
		.table_index(table_index), .critical_value(critical_value),
		.done(done), .statistic(statistic), .degrees_of_freedom(degrees_of_freedom),
		.below_critical(below_critical), .distinct_first(distinct_first),
		.distinct_second(distinct_second), .sample_total(sample_total),
		.count_saturated(count_saturated)
	);

	// mirror of the contingency table
	logic [15:0] cell_cnt [CATS*CATS];
	logic [15:0] row_sum [CATS];
	logic [15:0] col_sum [CATS];
	logic [15:0] n_seen;
	logic        sat_seen;
	logic [STAT_W-1:0] crit_tab [DF_DEPTH];

	sample_item_t pending_items[$];
	chi_result_t  expected_results[$];
	sample_item_t cur;
	bit   taken;
	int   gap, errors, accepted_items, total_items, idle_cycles;
	bit   burst;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic void clear_table();
		for (int i = 0; i < CATS*CATS; i++) cell_cnt[i] = '0;
		for (int i = 0; i < CATS; i++) begin
			row_sum[i] = '0;
			col_sum[i] = '0;
		end
		n_seen = '0;
		sat_seen = 1'b0;
	endfunction

	function automatic logic [15:0] bump(logic [15:0] v);
		if (v == COUNT_TOP) begin
			sat_seen = 1'b1;
			return v;
		end
		return v + 16'd1;
	endfunction

	function automatic chi_result_t evaluate_table();
		chi_result_t r;
		logic [63:0] on, rc, d, q, acc;
		logic [127:0] num, den;
		int nf, ns, dfv;
		bit over;
		acc = 0;
		over = 0;
		nf = 0;
		ns = 0;
		for (int i = 0; i < CATS; i++) begin
			if (row_sum[i] != 0) nf++;
			if (col_sum[i] != 0) ns++;
		end
		for (int i = 0; i < CATS; i++) begin
			for (int j = 0; j < CATS; j++) begin
				if (n_seen != 0 && row_sum[i] != 0 && col_sum[j] != 0) begin
					on = 64'(cell_cnt[i*CATS+j]) * 64'(n_seen);
					rc = 64'(row_sum[i]) * 64'(col_sum[j]);
					d = (on >= rc) ? on - rc : rc - on;
					num = (128'(d) * 128'(d)) << FRAC;
					den = 128'(64'(n_seen) * 64'(row_sum[i])) * 128'(col_sum[j]);
					if (num / den > 128'(STAT_TOP)) begin
						q = 64'(STAT_TOP);
						over = 1;
					end else begin
						q = 64'(num / den);
					end
					if (q > 64'(STAT_TOP) - acc) begin
						acc = 64'(STAT_TOP);
						over = 1;
					end else begin
						acc = acc + q;
					end
				end
			end
		end
		dfv = (nf != 0 && ns != 0) ? (nf - 1) * (ns - 1) : 0;
		r.stat = acc[STAT_W-1:0];
		r.df = DF_W'(dfv);
		r.below = (acc[STAT_W-1:0] < crit_tab[dfv]);
		r.dfirst = DIST_W'(nf);
		r.dsecond = DIST_W'(ns);
		r.total = n_seen;
		r.sat = sat_seen | over;
		return r;
	endfunction

	function automatic void apply_item(sample_item_t it);
		if (it.op == OP_LOAD) begin
			if (it.idx < DF_DEPTH) crit_tab[it.idx] = it.crit;
		end else begin
			cell_cnt[it.fc*CATS+it.sc] = bump(cell_cnt[it.fc*CATS+it.sc]);
			row_sum[it.fc] = bump(row_sum[it.fc]);
			col_sum[it.sc] = bump(col_sum[it.sc]);
			n_seen = bump(n_seen);
			if (it.last) begin
				expected_results.insert(expected_results.size(), evaluate_table());
				clear_table();
			end
		end
	endfunction

	function automatic logic [STAT_W-1:0] rand_crit();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return STAT_W'(w >> $urandom_range(24, 63));
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (burst || p < 60) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic add_count(int f, int s, bit last, bit drain = 0);
		sample_item_t it;
		it.op = OP_COUNT;
		it.fc = CODE_W'(f);
		it.sc = CODE_W'(s);
		it.last = last;
		it.idx = IDX_W'($urandom);
		it.crit = rand_crit();
		it.drain = drain;
		pending_items.insert(pending_items.size(), it);
		total_items++;
	endtask

	task automatic add_load(int idx, logic [STAT_W-1:0] val, bit last = 0);
		sample_item_t it;
		it.op = OP_LOAD;
		it.fc = CODE_W'($urandom);
		it.sc = CODE_W'($urandom);
		it.last = last;
		it.idx = IDX_W'(idx);
		it.crit = val;
		it.drain = 0;
		pending_items.insert(pending_items.size(), it);
		total_items++;
	endtask

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !taken) begin
			start <= 1'b1;
		end else if (gap > 0) begin
			start <= 1'b0;
			gap <= gap - 1;
		end else if (pending_items.size() != 0 &&
				!(pending_items[0].drain && (expected_results.size() != 0 || busy))) begin
			cur = pending_items.pop_front();
			operation <= cur.op;
			first_category <= cur.fc;
			second_category <= cur.sc;
			is_last <= cur.last;
			table_index <= cur.idx;
			critical_value <= cur.crit;
			start <= 1'b1;
			taken = 0;
			if ($urandom_range(0, 199) == 0) burst = !burst;
			gap <= pick_gap();
		end else begin
			start <= 1'b0;
		end
	end

	// monitor and predictor: everything sampled on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles = idle_cycles + 1;
			if (done) begin
				idle_cycles = 0;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result stat=%h df=%0d", $time, statistic,
						degrees_of_freedom);
					errors++;
				end else begin
					chi_result_t e;
					e = expected_results.pop_front();
					if (statistic !== e.stat) begin
						$display("%0t: statistic exp %h got %h", $time, e.stat, statistic);
						errors++;
					end
					if (degrees_of_freedom !== e.df) begin
						$display("%0t: degrees_of_freedom exp %0d got %0d", $time, e.df,
							degrees_of_freedom);
						errors++;
					end
					if (below_critical !== e.below) begin
						$display("%0t: below_critical exp %b got %b", $time, e.below,
							below_critical);
						errors++;
					end
					if (distinct_first !== e.dfirst) begin
						$display("%0t: distinct_first exp %0d got %0d", $time, e.dfirst,
							distinct_first);
						errors++;
					end
					if (distinct_second !== e.dsecond) begin
						$display("%0t: distinct_second exp %0d got %0d", $time, e.dsecond,
							distinct_second);
						errors++;
					end
					if (sample_total !== e.total) begin
						$display("%0t: sample_total exp %0d got %0d", $time, e.total,
							sample_total);
						errors++;
					end
					if (count_saturated !== e.sat) begin
						$display("%0t: count_saturated exp %b got %b", $time, e.sat,
							count_saturated);
						errors++;
					end
				end
			end
			if (start && !busy && !taken) begin
				idle_cycles = 0;
				taken = 1;
				accepted_items++;
				apply_item(cur);
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int len, span_f, span_s, base_f, base_s;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_COUNT;
		first_category = '0;
		second_category = '0;
		is_last = 1'b0;
		table_index = '0;
		critical_value = '0;
		taken = 1;
		gap = 0;
		burst = 0;
		errors = 0;
		accepted_items = 0;
		total_items = 0;
		idle_cycles = 0;
		cur = '{default: '0};
		clear_table();
		for (int i = 0; i < DF_DEPTH; i++) crit_tab[i] = '0;

		// every critical entry gets written so no read sees an unloaded one
		add_load(0, STAT_TOP);
		add_load(DF_DEPTH - 1, '0);
		for (int i = 1; i < DF_DEPTH - 1; i++) add_load(i, rand_crit());
		// out-of-range indexes are dropped, is_last on a load is ignored
		add_load(DF_DEPTH, '0, 1);
		add_load(255, STAT_TOP, 1);
		add_count(15, 15, 1);
		add_count(0, 0, 0);
		add_count(15, 15, 1);
		add_count(0, 15, 0);
		add_count(15, 0, 1, 1);
		for (int i = 0; i < CATS; i++) add_count(i, CATS - 1 - i, i == CATS - 1);
		add_load(DF_DEPTH - 1, 40'd1);
		for (int i = 0; i < CATS; i++) add_count(i, (i * 7) % CATS, i == CATS - 1);
		add_count(3, 9, 1, 1);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int k = 0; k < 880; ) begin
			if ($urandom_range(0, 9) == 0) begin
				add_load($urandom_range(0, 255), rand_crit(), $urandom_range(0, 1));
				k++;
			end else begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200)
					: $urandom_range(1, 25);
				span_f = $urandom_range(0, 15);
				span_s = $urandom_range(0, 15);
				base_f = $urandom_range(0, 15 - span_f);
				base_s = $urandom_range(0, 15 - span_s);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 7) == 0)
						add_count($urandom_range(0, 15), $urandom_range(0, 15), i == len - 1);
					else
						add_count(base_f + $urandom_range(0, span_f),
							base_s + $urandom_range(0, span_s), i == len - 1,
							i == 0 && $urandom_range(0, 29) == 0);
				end
				k += len;
			end
		end
		add_count(1, 2, 1);

		wait (accepted_items == total_items);
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
